FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers for the mixer RTL
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/stnm_pkg.sv
// ----------------------------------------------------------------------------
// stnm_pkg
// Types and constants of the square tone and noise mixer
// ----------------------------------------------------------------------------
`default_nettype none

package stnm_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_APPLY,
    ST_DRAW,
    ST_MIX,
    ST_OUT
  } state_e;

  typedef enum logic {
    REQ_SET  = 1'b0,
    REQ_TICK = 1'b1
  } req_e;

  localparam int unsigned  DIV_STEPS       = 16;
  localparam int unsigned  DIV_CNT_W       = 4;
  localparam logic [3:0]   DIV_LAST        = 4'(DIV_STEPS - 1);

  localparam logic [15:0]  SAMPLE_RATE_RST = 16'd44100;
  localparam logic [15:0]  LFSR_RST        = 16'hACE1;
  localparam logic [15:0]  SAMPLE_MAX      = 16'h7FFF;
  localparam logic [15:0]  SAMPLE_MIN      = 16'h8000;
  localparam logic [17:0]  NOISE_SPREAD    = 18'd75;

  // 150 * r built from shifts: 150 = 128 + 16 + 4 + 2
  function automatic logic [23:0] mul150(input logic [15:0] r);
    logic [23:0] rx;
    begin
      rx = {8'd0, r};
      mul150 = (rx << 7) + (rx << 4) + (rx << 2) + (rx << 1);
    end
  endfunction

  // volume * 5 as an 11-bit amplitude
  function automatic logic [10:0] mul5(input logic [7:0] v);
    logic [10:0] vx;
    begin
      vx = {3'd0, v};
      mul5 = (vx << 2) + vx;
    end
  endfunction

endpackage

`default_nettype wire

FILE: src/square_tone_noise_mixer.sv
// ----------------------------------------------------------------------------
// square_tone_noise_mixer
// Multi-channel square-wave tone and noise generator with a saturating mixer
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o) carries requests. req_type_i = 0
// programs channel_i with tone_freq_i and volume_i and returns nothing;
// req_type_i = 1 mixes all channels and returns one signed sample on the
// output channel (out_valid_o / out_stall_i, sample_o).
// A set request runs a bit-serial restoring divider (sample_rate / freq),
// one quotient bit per cycle, then an update step that writes the
// channel. A zero frequency or an out-of-range channel skips the
// divider.
// A sample request walks the channels one at a time (noise period draw,
// then mix for each channel), and then loads the output register.
// One request is worked on at a time; in_stall_o is high while busy.
// The output register holds a finished sample while out_stall_i is high and
// a new request may already be taken; a second sample waits for it.
// sample_rate is written through cfg_valid_i / cfg_ready_o while idle.
// Reset clears all channels, sets the sample rate to 44100 and the noise
// LFSR to 0xACE1; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module square_tone_noise_mixer #(
  parameter int unsigned TONE_CHANNELS  = 3,
  parameter int unsigned NOISE_CHANNELS = 3
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [15:0] cfg_sample_rate_i,
  // request channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        req_type_i,
  input  wire logic [2:0]  channel_i,
  input  wire logic [15:0] tone_freq_i,
  input  wire logic [7:0]  volume_i,
  // sample channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic signed [15:0] sample_o
);

  localparam int unsigned ALL  = TONE_CHANNELS + NOISE_CHANNELS;
  localparam int unsigned CH_W = (ALL > 1) ? $clog2(ALL) : 1;
  localparam int unsigned NS   = (NOISE_CHANNELS > 0) ? NOISE_CHANNELS : 1;
  localparam int unsigned NK_W = (NS > 1) ? $clog2(NS) : 1;
  localparam logic [CH_W-1:0] CH_LAST = CH_W'(ALL - 1);
  localparam int unsigned DIV_CNT_W_L = stnm_pkg::DIV_CNT_W;

  // state and storage
  stnm_pkg::state_e state_q, state_d;

  logic [15:0]     sample_rate_q;
  logic [15:0]     lfsr_q;
  logic [15:0]     period_q [ALL];
  logic [10:0]     amp_q    [ALL];
  logic [16:0]     phase_q  [ALL];
  logic [17:0]     noise_q  [NS];

  logic [CH_W-1:0] ch_cnt_q;
  logic [CH_W-1:0] set_idx_q;
  logic [7:0]      vol_q;
  logic [15:0]     div_q;
  logic [15:0]     quo_q, quo_d;
  logic [16:0]     rem_q, rem_d;
  logic [DIV_CNT_W_L-1:0] bit_cnt_q;
  logic [15:0]     acc_q, acc_d;
  logic            out_valid_q, out_valid_d;
  logic [15:0]     sample_q;

  // handshakes
  logic in_xfer, cfg_xfer, out_xfer, out_load;
  logic is_set, set_in_range, freq_zero;

  assign in_stall_o  = (state_q != stnm_pkg::ST_IDLE);
  assign cfg_ready_o = (state_q == stnm_pkg::ST_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign cfg_xfer    = cfg_valid_i && cfg_ready_o;
  assign out_xfer    = out_valid_q && !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign sample_o    = $signed(sample_q);

  assign is_set       = (req_type_i == stnm_pkg::REQ_SET);
  assign set_in_range = ({2'b00, channel_i} < 5'(ALL));
  assign freq_zero    = (tone_freq_i == 16'd0);

  // channel read port, shared by set update, noise draw and mixing
  logic [CH_W-1:0] rd_idx;
  logic [15:0]     period_rd;
  logic [10:0]     amp_rd;
  logic [16:0]     phase_rd;
  logic            is_noise;
  logic [NK_W-1:0] nk;
  logic [17:0]     noise_rd;
  logic            active;

  assign rd_idx    = (state_q == stnm_pkg::ST_APPLY) ? set_idx_q : ch_cnt_q;
  assign period_rd = period_q[rd_idx];
  assign amp_rd    = amp_q[rd_idx];
  assign phase_rd  = phase_q[rd_idx];
  assign is_noise  = ({1'b0, ch_cnt_q} >= (CH_W + 1)'(TONE_CHANNELS));
  assign nk        = is_noise ? NK_W'(ch_cnt_q - CH_W'(TONE_CHANNELS)) : '0;
  assign noise_rd  = noise_q[nk];
  assign active    = (period_rd != 16'd0) && (amp_rd != 11'd0);

  // divider step: one quotient bit per cycle
  logic [16:0] rem_sh;
  logic [17:0] rem_diff;
  logic        rem_ge;

  assign rem_sh   = {rem_q[15:0], quo_q[15]};
  assign rem_diff = {1'b0, rem_sh} - {2'b00, div_q};
  assign rem_ge   = !rem_diff[17];

  // noise draw
  logic [15:0] lfsr_nx;
  logic [23:0] draw_prod;
  logic [17:0] draw_period;
  logic        draw_en;

  assign lfsr_nx     = {lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5], lfsr_q[15:1]};
  assign draw_prod   = stnm_pkg::mul150(lfsr_nx);
  assign draw_period = {2'b00, period_rd} + {10'd0, draw_prod[23:16]}
                     - stnm_pkg::NOISE_SPREAD;
  assign draw_en     = (state_q == stnm_pkg::ST_DRAW) && is_noise && active
                     && (phase_rd == 17'd0);

  // mixing of one channel
  logic [17:0] cyc_len, cyc_half, ph_ext, ph_inc;
  logic        len_pos, in_first, in_second;
  logic [16:0] mix_sum;
  logic [15:0] mix_sat;
  logic [16:0] phase_nx;

  assign cyc_len   = is_noise ? noise_rd : {2'b00, period_rd};
  assign len_pos   = !cyc_len[17] && (cyc_len != 18'd0);
  assign cyc_half  = {1'b0, cyc_len[17:1]};
  assign ph_ext    = {1'b0, phase_rd};
  assign ph_inc    = ph_ext + 18'd1;
  assign in_first  = len_pos && (ph_ext < cyc_half);
  assign in_second = len_pos && !in_first && (ph_ext < cyc_len);
  assign phase_nx  = (!len_pos || (ph_inc >= cyc_len)) ? 17'd0 : ph_inc[16:0];

  always_comb begin
    mix_sum = {acc_q[15], acc_q};
    if (in_first) begin
      mix_sum = {acc_q[15], acc_q} + {6'd0, amp_rd};
    end else if (in_second) begin
      mix_sum = {acc_q[15], acc_q} - {6'd0, amp_rd};
    end
    if (mix_sum[16] != mix_sum[15]) begin
      mix_sat = mix_sum[16] ? stnm_pkg::SAMPLE_MIN : stnm_pkg::SAMPLE_MAX;
    end else begin
      mix_sat = mix_sum[15:0];
    end
  end

  // set update
  logic        per_change;
  logic [10:0] new_amp;

  assign per_change = (quo_q != period_rd);
  assign new_amp    = (quo_q == 16'd0) ? 11'd0 : stnm_pkg::mul5(vol_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      stnm_pkg::ST_IDLE: begin
        if (in_xfer) begin
          if (!is_set) begin
            state_d = stnm_pkg::ST_DRAW;
          end else if (!set_in_range) begin
            state_d = stnm_pkg::ST_IDLE;
          end else if (freq_zero) begin
            state_d = stnm_pkg::ST_APPLY;
          end else begin
            state_d = stnm_pkg::ST_DIV;
          end
        end
      end
      stnm_pkg::ST_DIV: begin
        if (bit_cnt_q == stnm_pkg::DIV_LAST) begin
          state_d = stnm_pkg::ST_APPLY;
        end
      end
      stnm_pkg::ST_APPLY: state_d = stnm_pkg::ST_IDLE;
      stnm_pkg::ST_DRAW:  state_d = stnm_pkg::ST_MIX;
      stnm_pkg::ST_MIX: begin
        state_d = (ch_cnt_q == CH_LAST) ? stnm_pkg::ST_OUT : stnm_pkg::ST_DRAW;
      end
      stnm_pkg::ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = stnm_pkg::ST_IDLE;
        end
      end
      default: state_d = stnm_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    quo_d       = quo_q;
    rem_d       = rem_q;
    acc_d       = acc_q;
    out_load    = 1'b0;
    out_valid_d = out_valid_q && !out_xfer;
    unique case (state_q)
      stnm_pkg::ST_IDLE: begin
        if (in_xfer) begin
          quo_d = freq_zero ? 16'd0 : sample_rate_q;
          rem_d = 17'd0;
          acc_d = 16'd0;
        end
      end
      stnm_pkg::ST_DIV: begin
        rem_d = rem_ge ? rem_diff[16:0] : rem_sh;
        quo_d = {quo_q[14:0], rem_ge};
      end
      stnm_pkg::ST_MIX: begin
        if (active) begin
          acc_d = mix_sat;
        end
      end
      stnm_pkg::ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= stnm_pkg::ST_IDLE;
      out_valid_q   <= 1'b0;
      sample_rate_q <= stnm_pkg::SAMPLE_RATE_RST;
      lfsr_q        <= stnm_pkg::LFSR_RST;
      ch_cnt_q      <= '0;
      bit_cnt_q     <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_xfer) begin
        sample_rate_q <= cfg_sample_rate_i;
      end
      if (draw_en) begin
        lfsr_q <= lfsr_nx;
      end
      if (in_xfer) begin
        ch_cnt_q  <= '0;
        bit_cnt_q <= '0;
      end else begin
        if (state_q == stnm_pkg::ST_MIX) begin
          ch_cnt_q <= ch_cnt_q + CH_W'(1);
        end
        if (state_q == stnm_pkg::ST_DIV) begin
          bit_cnt_q <= bit_cnt_q + DIV_CNT_W_L'(1);
        end
      end
    end
  end

  // channel state, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ALL; i++) begin
        period_q[i] <= 16'd0;
        amp_q[i]    <= 11'd0;
        phase_q[i]  <= 17'd0;
      end
      for (int j = 0; j < NS; j++) begin
        noise_q[j] <= 18'd0;
      end
    end else begin
      if (state_q == stnm_pkg::ST_APPLY) begin
        if (per_change) begin
          period_q[rd_idx] <= quo_q;
          phase_q[rd_idx]  <= 17'd0;
        end
        amp_q[rd_idx] <= new_amp;
      end
      if ((state_q == stnm_pkg::ST_MIX) && active) begin
        phase_q[rd_idx] <= phase_nx;
      end
      if (draw_en) begin
        noise_q[nk] <= draw_period;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    acc_q <= acc_d;
    if (in_xfer) begin
      set_idx_q <= CH_W'(channel_i);
      vol_q     <= volume_i;
      div_q     <= tone_freq_i;
    end
    if (out_load) begin
      sample_q <= acc_q;
    end
  end

  // conditions watched by the assertions
  logic div_last, tone_mix;

  assign div_last = (state_q == stnm_pkg::ST_DIV) && (bit_cnt_q == stnm_pkg::DIV_LAST);
  assign tone_mix = (state_q == stnm_pkg::ST_MIX) && !is_noise && active;

  `ASSERT_ALWAYS(a_lfsr_nonzero, lfsr_q != 16'd0, "noise lfsr reached the all-zero lock state")
  `ASSERT_NEXT(a_div_done, div_last, state_q == stnm_pkg::ST_APPLY, "divider overran")
  `ASSERT_IMPL(a_tone_phase, tone_mix, phase_rd < period_rd, "tone phase outside its period")
  `ASSERT_IMPL(a_out_rise, $rose(out_valid_q), $past(out_load), "sample without a finished mix")

endmodule

`default_nettype wire
